// ----- src/hst_pkg.sv -----
// ============================================================================
// hst_pkg - shared types and codes for the handle slot table
// Request and status codes, controller states and the free stack command.
// ============================================================================
`default_nettype none

package hst_pkg;

  localparam int SLOT_W   = 10;
  localparam int HANDLE_W = 64;

  typedef enum logic [1:0] {
    REQ_REG   = 2'd0,
    REQ_UNREG = 2'd1,
    REQ_GET   = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_RANGE      = 2'd2,
    ST_STACK_FULL = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // free stack command: rd fetches the top entry, pop/push move the count
  typedef struct packed {
    logic rd;
    logic pop;
    logic push;
  } fs_cmd_t;

endpackage

`default_nettype wire

// ----- src/hst_handle_mem.sv -----
// ============================================================================
// hst_handle_mem - handle storage
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module hst_handle_mem import hst_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output logic [HANDLE_W-1:0] rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [HANDLE_W-1:0] wr_data
);

  logic [HANDLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/hst_free_stack.sv -----
// ============================================================================
// hst_free_stack - LIFO of freed slots
// Stack memory plus fill count. The top entry is fetched into a register
// ahead of the pop that consumes it.
// ============================================================================
`default_nettype none

module hst_free_stack import hst_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int CW    = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  fs_cmd_t       cmd,
  input  logic [AW-1:0] push_slot,
  output logic [AW-1:0] top_slot,
  output logic [CW-1:0] count
);

  logic [AW-1:0] mem [DEPTH];

  // push is never issued with the stack full, so the truncated count is valid
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[AW'(count)] <= push_slot;
    end
  end

  // top fetch; address wraps when empty and the data is then unused
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      top_slot <= mem[AW'(count - CW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.pop) begin
      count <= count - CW'(1);
    end else if (cmd.push) begin
      count <= count + CW'(1);
    end
  end

endmodule

`default_nettype wire

// ----- src/handle_slot_table_top.sv -----
// ============================================================================
// handle_slot_table_top - slot table for 64-bit object handles
// Hands out slot indices, frees them onto a LIFO and looks handles up.
// ============================================================================
// Each item is handled in the accept cycle, where the handle memory and the
// free stack top are read, and then in the update state, where the result
// is formed and any write back to the memories is done. The next item is
// taken once that write back is finished, so two items never touch the
// memories at once. The result sits in an output register; an item is held
// in the update state only while an earlier result is still stalled there.
// Memory contents need no clearing after reset: only entries below the
// high-water mark or the free count are ever read.
`default_nettype none

module handle_slot_table_top import hst_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [HANDLE_W-1:0] object_handle,
  input  logic [SLOT_W-1:0]   slot_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   result_slot,
  output logic [HANDLE_W-1:0] result_handle,
  output logic [1:0]          status
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = (CW > SLOT_W) ? CW : SLOT_W;

  state_t              state, state_next;
  logic [1:0]          req_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [SLOT_W-1:0]   idx_q;
  logic [CW-1:0]       high_water, high_water_next;

  logic                accept;
  logic                commit;
  fs_cmd_t             fs_cmd;
  logic [AW-1:0]       fs_top;
  logic [CW-1:0]       fs_count;
  logic [HANDLE_W-1:0] mem_rd_data;
  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [HANDLE_W-1:0] mem_wr_data;
  logic                in_range;

  logic [SLOT_W-1:0]   res_slot;
  logic [HANDLE_W-1:0] res_handle;
  status_t             res_status;

  assign accept   = (state == S_IDLE) && in_valid;
  assign in_stall = (state != S_IDLE);
  assign commit   = (state == S_EXEC) && (!out_valid || !out_stall);
  assign in_range = EW'(idx_q) < EW'(high_water);

  hst_handle_mem #(.DEPTH(SLOTS), .AW(AW)) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (AW'(slot_index)),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  hst_free_stack #(.DEPTH(SLOTS), .AW(AW), .CW(CW)) u_stack (
    .clk       (clk),
    .rst       (rst),
    .cmd       (fs_cmd),
    .push_slot (AW'(idx_q)),
    .top_slot  (fs_top),
    .count     (fs_count)
  );

  always_comb begin
    state_next      = state;
    high_water_next = high_water;
    fs_cmd          = '{rd: accept, pop: 1'b0, push: 1'b0};
    mem_wr_en       = 1'b0;
    mem_wr_addr     = AW'(idx_q);
    mem_wr_data     = '0;
    res_slot        = idx_q;
    res_handle      = '0;
    res_status      = ST_OK;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_q)
          REQ_REG: begin
            if (fs_count != '0) begin
              fs_cmd.pop  = commit;
              mem_wr_en   = commit;
              mem_wr_addr = fs_top;
              mem_wr_data = handle_q;
              res_slot    = SLOT_W'(fs_top);
            end else if (high_water != CW'(SLOTS)) begin
              high_water_next = high_water + CW'(1);
              mem_wr_en       = commit;
              mem_wr_addr     = AW'(high_water);
              mem_wr_data     = handle_q;
              res_slot        = SLOT_W'(high_water);
            end else begin
              res_slot   = '0;
              res_status = ST_FULL;
            end
          end
          REQ_UNREG: begin
            if (!in_range) begin
              res_status = ST_RANGE;
            end else begin
              mem_wr_en = commit;
              if (fs_count != CW'(SLOTS)) begin
                fs_cmd.push = commit;
              end else begin
                res_status = ST_STACK_FULL;
              end
            end
          end
          REQ_GET: begin
            if (!in_range) begin
              res_status = ST_RANGE;
            end else begin
              res_handle = mem_rd_data;
            end
          end
          default: begin
          end
        endcase
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      high_water <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        high_water <= high_water_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q    <= req_type;
      handle_q <= object_handle;
      idx_q    <= slot_index;
    end
    if (commit) begin
      result_slot   <= res_slot;
      result_handle <= res_handle;
      status        <= res_status;
    end
  end

endmodule

`default_nettype wire

// ----- src/hst_checker.sv -----
// ============================================================================
// hst_checker - port level checks for the handle slot table
// Watches the top level ports only; attached by bind below.
// ============================================================================
`default_nettype none

module hst_checker import hst_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [SLOT_W-1:0]   result_slot,
  input logic [HANDLE_W-1:0] result_handle,
  input logic [1:0]          status
);

  // one item in flight: the cycle after an accept must stall
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while previous item still in work");

  // a new result only appears out of the update cycle
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  a_err_zero_handle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (result_handle == '0))
    else $error("nonzero handle on error status");

  a_full_zero_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (result_slot == '0))
    else $error("table full result with nonzero slot");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(result_slot) && $stable(result_handle) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind handle_slot_table_top hst_checker u_hst_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .result_slot   (result_slot),
  .result_handle (result_handle),
  .status        (status)
);

`default_nettype wire
